>>> rtl/sri_pkg.sv
package sri_pkg;

  localparam int unsigned A_W      = 32;           // interval bound width
  localparam int unsigned N_W      = 17;           // step count field width
  localparam int unsigned R_W      = 32;           // integral width
  localparam int unsigned MH_W     = 49;           // |b - a| << 16 and its quotient
  localparam int unsigned X_W      = 51;           // sample angle, Q.44
  localparam int unsigned ANG_W    = 35;           // rounded sample angle, Q.28
  localparam int unsigned RZ_W     = 36;           // angle during range reduction
  localparam int unsigned Z_W      = 32;           // CORDIC angle
  localparam int unsigned XY_W     = 33;           // CORDIC vector, Q.30
  localparam int unsigned N_FIELD_MAX = 131071;

  localparam int unsigned DEF_MAX_STEPS     = 65536;
  localparam int unsigned DEF_CORDIC_STAGES = 24;

  localparam logic signed [RZ_W-1:0] PI_Q28      = 36'sd843314857;
  localparam logic signed [RZ_W-1:0] HALF_PI_Q28 = 36'sd421657428;
  localparam logic signed [RZ_W-1:0] TWO_PI_Q28  = 36'sd1686629713;
  localparam logic signed [XY_W-1:0] GAIN_Q30    = 33'sd652032874;

  // arctan(2^-i) in Q.28, rounded
  function automatic logic signed [Z_W-1:0] atan_q28(input int unsigned i);
    logic signed [Z_W-1:0] v;
    case (i)
      0:  v = 32'sd210828714;
      1:  v = 32'sd124459457;
      2:  v = 32'sd65760959;
      3:  v = 32'sd33381290;
      4:  v = 32'sd16755422;
      5:  v = 32'sd8385879;
      6:  v = 32'sd4193963;
      7:  v = 32'sd2097109;
      8:  v = 32'sd1048571;
      9:  v = 32'sd524287;
      default: begin
        if (i >= 29) v = 32'sd1;
        else         v = Z_W'(32'sd1 <<< (28 - i));
      end
    endcase
    return v;
  endfunction

  typedef struct packed {
    logic load;
    logic div_step;
    logic issue;
    logic mul_start;
    logic mul_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic in_zero;
    logic last_issue;
    logic pipe_empty;
    logic out_free;
  } sts_t;

endpackage

>>> rtl/sri_sine_pipe.sv
module sri_sine_pipe
  import sri_pkg::*;
#(
  parameter int unsigned CORDIC_STAGES = DEF_CORDIC_STAGES
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  input  logic signed [ANG_W-1:0] ang_i,
  output logic                    out_valid_o,
  output logic signed [XY_W-1:0]  sin_o,
  output logic                    empty_o
);

  // range reduction: input register, four greedy stages, one final stage
  localparam int unsigned RED_N = 6;

  logic signed [RZ_W-1:0] rz_q [RED_N];
  logic                   rv_q [RED_N];
  logic signed [Z_W-1:0]  fz_q;
  logic                   fv_q;
  logic signed [XY_W-1:0] cx_q [CORDIC_STAGES+1];
  logic signed [XY_W-1:0] cy_q [CORDIC_STAGES+1];
  logic signed [Z_W-1:0]  cz_q [CORDIC_STAGES+1];
  logic                   cv_q [CORDIC_STAGES+1];
  logic [RED_N+CORDIC_STAGES+1:0] vbits;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) rv_q[0] <= 1'b0;
    else         rv_q[0] <= in_valid_i;
  end

  always_ff @(posedge clk_i) begin
    rz_q[0] <= RZ_W'(ang_i);
  end

  // subtract or add 2pi * 2^k while the angle stays beyond pi
  for (genvar g = 1; g < 5; g++) begin : g_greedy
    localparam logic signed [RZ_W-1:0] C = RZ_W'(TWO_PI_Q28 <<< (4 - g));
    logic signed [RZ_W-1:0] zs, za;
    assign zs = rz_q[g-1] - C;
    assign za = rz_q[g-1] + C;
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) rv_q[g] <= 1'b0;
      else         rv_q[g] <= rv_q[g-1];
    end
    always_ff @(posedge clk_i) begin
      if (zs > PI_Q28)       rz_q[g] <= zs;
      else if (za < -PI_Q28) rz_q[g] <= za;
      else                   rz_q[g] <= rz_q[g-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) rv_q[5] <= 1'b0;
    else         rv_q[5] <= rv_q[4];
  end

  always_ff @(posedge clk_i) begin
    if (rz_q[4] > PI_Q28)       rz_q[5] <= rz_q[4] - TWO_PI_Q28;
    else if (rz_q[4] < -PI_Q28) rz_q[5] <= rz_q[4] + TWO_PI_Q28;
    else                        rz_q[5] <= rz_q[4];
  end

  // fold into [-pi/2, pi/2]
  logic signed [RZ_W-1:0] fz_d;
  always_comb begin
    if (rz_q[5] > HALF_PI_Q28)       fz_d = PI_Q28 - rz_q[5];
    else if (rz_q[5] < -HALF_PI_Q28) fz_d = -PI_Q28 - rz_q[5];
    else                             fz_d = rz_q[5];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) fv_q <= 1'b0;
    else         fv_q <= rv_q[5];
  end

  always_ff @(posedge clk_i) begin
    fz_q <= fz_d[Z_W-1:0];
  end

  assign cx_q[0] = GAIN_Q30;
  assign cy_q[0] = '0;
  assign cz_q[0] = fz_q;
  assign cv_q[0] = fv_q;

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cordic
    localparam logic signed [Z_W-1:0] ATAN = atan_q28(g);
    logic signed [XY_W-1:0] s, t;
    assign s = cx_q[g] >>> g;
    assign t = cy_q[g] >>> g;
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) cv_q[g+1] <= 1'b0;
      else         cv_q[g+1] <= cv_q[g];
    end
    always_ff @(posedge clk_i) begin
      if (!cz_q[g][Z_W-1]) begin
        cx_q[g+1] <= cx_q[g] - t;
        cy_q[g+1] <= cy_q[g] + s;
        cz_q[g+1] <= cz_q[g] - ATAN;
      end else begin
        cx_q[g+1] <= cx_q[g] + t;
        cy_q[g+1] <= cy_q[g] - s;
        cz_q[g+1] <= cz_q[g] + ATAN;
      end
    end
  end

  always_comb begin
    for (int k = 0; k < RED_N; k++) vbits[k] = rv_q[k];
    for (int k = 0; k <= CORDIC_STAGES; k++) vbits[RED_N+k] = cv_q[k];
    vbits[RED_N+CORDIC_STAGES+1] = in_valid_i;
  end

  assign empty_o     = ~|vbits;
  assign out_valid_o = cv_q[CORDIC_STAGES];
  assign sin_o       = cy_q[CORDIC_STAGES];

endmodule

>>> rtl/sri_datapath.sv
module sri_datapath
  import sri_pkg::*;
#(
  parameter int unsigned MAX_STEPS     = DEF_MAX_STEPS,
  parameter int unsigned CORDIC_STAGES = DEF_CORDIC_STAGES
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  cmd_t                   cmd_i,
  output sts_t                   sts_o,
  input  logic signed [A_W-1:0]  lower_i,
  input  logic signed [A_W-1:0]  upper_i,
  input  logic [N_W-1:0]         steps_i,
  input  logic                   out_ready_i,
  output logic                   out_valid_o,
  output logic signed [R_W-1:0]  out_data_o
);

  localparam int unsigned EFF   = (MAX_STEPS < N_FIELD_MAX) ? MAX_STEPS : N_FIELD_MAX;
  localparam int unsigned CNT_W = $clog2(EFF + 1);
  localparam int unsigned SUM_W = XY_W + 1 + CNT_W;
  localparam int unsigned PW    = SUM_W + MH_W;
  localparam int unsigned MAG_W = PW + 1 - (MH_W - 1);
  localparam logic [CNT_W-1:0] EFF_C = CNT_W'(EFF);

  logic [CNT_W-1:0]        n_q, icnt_q, rem_q, n_eff;
  logic [MH_W-1:0]         dq_q;       // dividend, then quotient |h|
  logic                    dneg_q, zero_q;
  logic signed [X_W-1:0]   x_q;
  logic signed [SUM_W-1:0] sum_q;
  logic [SUM_W-1:0]        msum_q;
  logic [PW-1:0]           p_q;
  logic                    neg_q;
  logic                    ov_q;
  logic signed [R_W-1:0]   od_q;

  // clamp the step count
  assign n_eff = ({8'b0, steps_i} > 25'(EFF)) ? EFF_C : steps_i[CNT_W-1:0];

  logic signed [A_W:0]   diff;
  logic [A_W:0]          adiff;
  assign diff  = (A_W+1)'(upper_i) - (A_W+1)'(lower_i);
  assign adiff = diff[A_W] ? -diff : diff;

  // restoring division, one quotient bit a cycle
  logic [CNT_W:0] trial;
  logic           take;
  assign trial = {rem_q, dq_q[MH_W-1]};
  assign take  = trial >= {1'b0, n_q};

  logic signed [MH_W:0]  hval;
  logic signed [X_W-1:0] x_rnd;
  assign hval  = dneg_q ? -$signed({1'b0, dq_q}) : $signed({1'b0, dq_q});
  assign x_rnd = x_q + X_W'(32768);

  logic                   s_valid;
  logic signed [XY_W-1:0] s_sin;
  logic                   s_empty;

  sri_sine_pipe #(
    .CORDIC_STAGES(CORDIC_STAGES)
  ) u_sine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (cmd_i.issue),
    .ang_i      (x_rnd[X_W-1:16]),
    .out_valid_o(s_valid),
    .sin_o      (s_sin),
    .empty_o    (s_empty)
  );

  // shift-add multiply step
  logic [SUM_W:0] madd;
  assign madd = {1'b0, p_q[PW-1:MH_W]} + (p_q[0] ? {1'b0, msum_q} : '0);

  // round half away from zero, then saturate
  logic [PW:0]          prnd;
  logic [MAG_W-1:0]     mag;
  logic signed [R_W-1:0] res;
  assign prnd = {1'b0, p_q} + ((PW+1)'(1) << (MH_W - 2));
  assign mag  = prnd[PW:MH_W-1];
  always_comb begin
    if (neg_q) begin
      if (mag > MAG_W'(33'h080000000)) res = 32'sh80000000;
      else                             res = -$signed(mag[R_W-1:0]);
    end else begin
      if (mag > MAG_W'(32'h7fffffff))  res = 32'sh7fffffff;
      else                             res = $signed(mag[R_W-1:0]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      n_q    <= n_eff;
      zero_q <= (steps_i == '0);
      dneg_q <= diff[A_W];
      dq_q   <= {adiff[MH_W-17:0], 16'b0};
      rem_q  <= '0;
      x_q    <= X_W'(lower_i) <<< 16;
      icnt_q <= '0;
    end else if (cmd_i.div_step) begin
      rem_q <= take ? CNT_W'(trial - {1'b0, n_q}) : trial[CNT_W-1:0];
      dq_q  <= {dq_q[MH_W-2:0], take};
    end else if (cmd_i.issue) begin
      x_q    <= x_q + X_W'(hval);
      icnt_q <= icnt_q + 1'b1;
    end
    if (cmd_i.load)      sum_q <= '0;
    else if (s_valid)    sum_q <= sum_q + SUM_W'(s_sin);
    if (cmd_i.mul_start) begin
      msum_q <= sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
      neg_q  <= sum_q[SUM_W-1] ^ dneg_q;
      p_q    <= {{SUM_W{1'b0}}, dq_q};
    end else if (cmd_i.mul_step) begin
      p_q <= {madd, p_q[MH_W-1:1]};
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)               ov_q <= 1'b0;
    else if (cmd_i.out_load)   ov_q <= 1'b1;
    else if (out_ready_i)      ov_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) od_q <= zero_q ? '0 : res;
  end

  assign out_valid_o     = ov_q;
  assign out_data_o      = od_q;
  assign sts_o.in_zero    = (steps_i == '0);
  assign sts_o.last_issue = (icnt_q == n_q - 1'b1);
  assign sts_o.pipe_empty = s_empty;
  assign sts_o.out_free   = ~ov_q | out_ready_i;

endmodule

>>> rtl/sri_ctrl.sv
module sri_ctrl
  import sri_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DIV   = 3'd1;
  localparam logic [2:0] S_RUN   = 3'd2;
  localparam logic [2:0] S_DRAIN = 3'd3;
  localparam logic [2:0] S_MUL   = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  localparam int unsigned C_W = $clog2(MH_W);
  localparam logic [C_W-1:0] C_LAST = C_W'(MH_W - 1);

  logic [2:0]     state_q, state_d;
  logic [C_W-1:0] cnt_q, cnt_d;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          cnt_d      = '0;
          state_d    = sts_i.in_zero ? S_OUT : S_DIV;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == C_LAST) state_d = S_RUN;
      end
      S_RUN: begin
        cmd_o.issue = 1'b1;
        if (sts_i.last_issue) state_d = S_DRAIN;
      end
      S_DRAIN: begin
        if (sts_i.pipe_empty) begin
          cmd_o.mul_start = 1'b1;
          cnt_d           = '0;
          state_d         = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.mul_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == C_LAST) state_d = S_OUT;
      end
      S_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

endmodule

>>> rtl/sine_rectangle_rule_integrator.sv
// One word is taken at a time: a new word is accepted only once the last
// result is loaded into the result register. Samples are issued one per
// cycle into the pipelined CORDIC, between the divider and the multiplier;
// a zero step count skips straight to the result, which is zero.
// Reset (rst_ni low, asynchronous) clears the controller, pipeline valids and
// the result valid flag; payload registers are not reset.
module sine_rectangle_rule_integrator
  import sri_pkg::*;
#(
  parameter int unsigned MAX_STEPS     = DEF_MAX_STEPS,
  parameter int unsigned CORDIC_STAGES = DEF_CORDIC_STAGES
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // lower_bound [31:0], upper_bound [63:32], step_count [80:64], zeros above
  input  logic [87:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // integral [31:0]
  output logic [31:0] m_axis_tdata
);

  cmd_t                  cmd;
  sts_t                  sts;
  logic signed [R_W-1:0] res;

  // sequence the divide, sample, drain, multiply and hand-off phases
  sri_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .in_ready_o(s_axis_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  // step divider, angle accumulator, CORDIC, sum and final multiply
  sri_datapath #(
    .MAX_STEPS    (MAX_STEPS),
    .CORDIC_STAGES(CORDIC_STAGES)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .lower_i    ($signed(s_axis_tdata[31:0])),
    .upper_i    ($signed(s_axis_tdata[63:32])),
    .steps_i    (s_axis_tdata[80:64]),
    .out_ready_i(m_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .out_data_o (res)
  );

  assign m_axis_tdata = res;

endmodule

>>> tb/sv/sine_rectangle_rule_integrator_tb.sv
module sine_rectangle_rule_integrator_tb;
  import sri_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned STAGES   = DEF_CORDIC_STAGES;
  localparam int unsigned STEP_MAX = DEF_MAX_STEPS;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  // lower_bound [31:0], upper_bound [63:32], step_count [80:64], zeros above
  logic [87:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  // integral [31:0]
  logic [31:0] m_axis_tdata;

  // arctan(2^-i) table, Q.28, built once at time zero
  longint      atan_tab [STAGES];
  logic [31:0] integral_q[$];
  int unsigned mismatches;
  bit          stall_en;  // clear for a stretch with no idling on either side

  sine_rectangle_rule_integrator dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs
  initial begin
    #40ms;
    $display("Mismatches found");
    $finish;
  end

  // Build the arctan table: alternating series in Q.60, rounded to Q.28
  function automatic void build_atan();
    longint unsigned acc;
    int unsigned     e;
    atan_tab[0] = 64'sd210828714;
    for (int unsigned i = 1; i < STAGES; i++) begin
      acc = 0;
      for (int unsigned k = 0; 60 >= i * (2 * k + 1); k++) begin
        e = 60 - i * (2 * k + 1);
        if (k & 1) acc -= (64'd1 << e) / (2 * k + 1);
        else       acc += (64'd1 << e) / (2 * k + 1);
      end
      atan_tab[i] = longint'((acc + (64'd1 << 31)) >> 32);
    end
  endfunction

  // Reduce the angle into [-pi/2, pi/2] and rotate; sine in Q.30
  function automatic longint cordic_sine(longint ang);
    longint x, y, z, s, t;
    x = GAIN_Q30;
    y = 0;
    z = ang;
    while (z > longint'(PI_Q28))  z -= longint'(TWO_PI_Q28);
    while (z < -longint'(PI_Q28)) z += longint'(TWO_PI_Q28);
    if (z > longint'(HALF_PI_Q28))       z = longint'(PI_Q28) - z;
    else if (z < -longint'(HALF_PI_Q28)) z = -longint'(PI_Q28) - z;
    for (int unsigned i = 0; i < STAGES; i++) begin
      s = x >>> i;
      t = y >>> i;
      if (z >= 0) begin
        x -= t; y += s; z -= atan_tab[i];
      end else begin
        x += t; y -= s; z += atan_tab[i];
      end
    end
    return y;
  endfunction

  // Left rectangle sum of sine over [lo, hi] with n steps, Q6.26
  function automatic logic [31:0] rect_integral(logic signed [31:0] lo,
                                                logic signed [31:0] hi,
                                                logic [16:0] n_f);
    longint          a, diff, h, sum, xq;
    longint unsigned n, mh, msum;
    logic [127:0]    prod;
    logic [63:0]     mag;
    bit              neg;
    n = n_f;
    if (n == 0) return '0;
    if (n > STEP_MAX) n = STEP_MAX;
    a    = lo;
    diff = longint'(hi) - a;
    mh   = longint'((diff < 0) ? -diff : diff) << 16;
    mh   = mh / n;
    h    = (diff < 0) ? -longint'(mh) : longint'(mh);
    sum  = 0;
    for (longint unsigned i = 0; i < n; i++) begin
      xq  = a * 65536 + longint'(i) * h;
      sum += cordic_sine((xq + 32768) >>> 16);
    end
    neg  = (sum < 0) != (h < 0);
    msum = (sum < 0) ? -sum : sum;
    prod = {64'd0, msum} * {64'd0, mh};
    prod += 128'd1 << 47;
    if (prod[127:112] != 0) mag = 64'd1 << 32;
    else                    mag = prod[111:48];
    if (neg) begin
      if (mag > 64'h8000_0000) mag = 64'h8000_0000;
      return 32'(64'd0 - mag);
    end
    if (mag > 64'h7FFF_FFFF) mag = 64'h7FFF_FFFF;
    return mag[31:0];
  endfunction

  task automatic report_mismatch(input string kind, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("integral %s: got %h, want %h", kind, got, want);
    mismatches++;
  endtask

  // Send one word; hold tvalid high straight into the next word unless idling
  task automatic send_request(input logic [31:0] lo, input logic [31:0] hi,
                              input logic [16:0] n);
    while (stall_en && $urandom_range(99) < 30) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, n, hi, lo};
    integral_q.push_back(rect_integral(lo, hi, n));
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Random receiver stalls
  always @(posedge clk_i) begin
    m_axis_tready <= !stall_en || ($urandom_range(99) >= 30);
  end

  // Check every accepted result word against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (integral_q.size() == 0) begin
        report_mismatch("unexpected word", m_axis_tdata, 32'hx);
      end else begin
        logic [31:0] want;
        want = integral_q.pop_front();
        if (m_axis_tdata !== want) report_mismatch("mismatch", m_axis_tdata, want);
      end
    end
  end

  // Extremes of the bounds, zero and single steps
  task automatic test_directed();
    send_request(32'h0000_0000, 32'h0000_0000, 17'd1);
    send_request(32'h8000_0000, 32'h7FFF_FFFF, 17'd1);
    send_request(32'h7FFF_FFFF, 32'h8000_0000, 17'd1);
    send_request(32'h8000_0000, 32'h7FFF_FFFF, 17'd0);
    send_request(32'h1234_5678, 32'h8765_4321, 17'd0);
    send_request(32'h0000_0000, 32'd843314857, 17'd16);   // 0 .. pi
    send_request(32'd843314857, 32'h0000_0000, 17'd16);   // pi .. 0
    send_request(32'h8000_0000, 32'h7FFF_FFFF, 17'd64);
    send_request(32'h7FFF_FFFF, 32'h8000_0000, 17'd33);
    send_request(32'hF000_0000, 32'h1000_0000, 17'd7);
    send_request(32'h0000_0001, 32'h0000_0002, 17'd3);    // step rounds to tiny
    send_request(32'd421657428, 32'd421657429, 17'd2);    // around pi/2
  endtask

  // Large counts: the full field and the clamp above the step limit
  task automatic test_large_counts();
    send_request(32'h8000_0000, 32'h7FFF_FFFF, 17'h0FFFF);
    send_request(32'h0000_0000, 32'd1686629713, 17'h10000);
    send_request(32'h7FFF_FFFF, 32'h8000_0000, 17'h1FFFF);
  endtask

  task automatic test_random();
    logic [16:0] n;
    for (int i = 0; i < 100; i++) begin
      if (i == 40) stall_en = 1'b0;
      if (i == 60) stall_en = 1'b1;
      if ($urandom_range(9) == 0) n = 17'($urandom_range(300));
      else                        n = 17'($urandom_range(40, 1));
      send_request($urandom, $urandom, n);
    end
  endtask

  initial begin
    int unsigned guard;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    stall_en      = 1'b1;
    mismatches    = 0;
    build_atan();
    rst_ni = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_large_counts();
    test_random();
    s_axis_tvalid <= 1'b0;

    // Drain: wait for every expected word, then run on before reporting
    guard = 0;
    while (integral_q.size() != 0 && guard < 400000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (300) @(posedge clk_i);
    if (mismatches == 0 && integral_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/sri_pkg.sv
rtl/sri_sine_pipe.sv
rtl/sri_datapath.sv
rtl/sri_ctrl.sv
rtl/sine_rectangle_rule_integrator.sv
tb/sv/sine_rectangle_rule_integrator_tb.sv
